// File: rtl/ttl_pkg.sv
// Shared types and constants of the TTL/LFU cache policy block.
package ttl_pkg;

    localparam int HIT_W     = 16;
    localparam int TIME_W    = 32;
    localparam int TOTAL_W   = 32;
    localparam int MAXE_W    = 5;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTECT     = 2'd2;

    localparam logic [MAXE_W-1:0] RST_MAX_ENTRIES = 5'd16;
    localparam logic [TIME_W-1:0] RST_LIFETIME    = 32'd30000;
    localparam logic [HIT_W-1:0]  RST_PROTECT     = 16'd10;

    localparam logic [HIT_W-1:0]   HIT_MAX   = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // flags of the scan wave travelling down the cell chain
    typedef struct packed {
        logic vld;
        logic match_ok;
        logic match_fresh;
        logic vic_ok;
        logic free_ok;
    } t_scan;

    // update request broadcast to all cells after a scan
    typedef struct packed {
        logic clear;
        logic hit_en;
        logic kill_en;
        logic evict_en;
        logic wr_en;
    } t_cmd;

endpackage

// File: rtl/ttl_cell.sv
// One cache slot cell: holds a slot and folds it into the passing scan wave.
module ttl_cell #(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int CELL_IDX  = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [KEY_BITS-1:0]       i_key,
    input  logic [ttl_pkg::TIME_W-1:0] i_now,
    input  logic [ttl_pkg::TIME_W-1:0] i_lifetime,
    input  logic [ttl_pkg::HIT_W-1:0] i_protect,
    input  ttl_pkg::t_scan            i_scan,
    input  logic [IDX_W-1:0]          i_match_idx,
    input  logic [DATA_BITS-1:0]      i_match_data,
    input  logic [IDX_W-1:0]          i_vic_idx,
    input  logic [ttl_pkg::HIT_W-1:0] i_vic_hits,
    input  logic [ttl_pkg::TIME_W-1:0] i_vic_age,
    input  logic [KEY_BITS-1:0]       i_vic_key,
    input  logic [IDX_W-1:0]          i_free_idx,
    input  logic [CNT_W-1:0]          i_used_cnt,
    output ttl_pkg::t_scan            o_scan,
    output logic [IDX_W-1:0]          o_match_idx,
    output logic [DATA_BITS-1:0]      o_match_data,
    output logic [IDX_W-1:0]          o_vic_idx,
    output logic [ttl_pkg::HIT_W-1:0] o_vic_hits,
    output logic [ttl_pkg::TIME_W-1:0] o_vic_age,
    output logic [KEY_BITS-1:0]       o_vic_key,
    output logic [IDX_W-1:0]          o_free_idx,
    output logic [CNT_W-1:0]          o_used_cnt,
    input  ttl_pkg::t_cmd             i_cmd,
    input  logic [IDX_W-1:0]          i_cmd_match_idx,
    input  logic [IDX_W-1:0]          i_cmd_vic_idx,
    input  logic [IDX_W-1:0]          i_cmd_wr_idx,
    input  logic [DATA_BITS-1:0]      i_wr_data
);
    import ttl_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                 r_used, r_live;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_data;
    logic [TIME_W-1:0]    r_cached, r_last;
    logic [HIT_W-1:0]     r_hits;

    t_scan                r_scan;
    logic [IDX_W-1:0]     r_match_idx, r_vic_idx, r_free_idx;
    logic [DATA_BITS-1:0] r_match_data;
    logic [HIT_W-1:0]     r_vic_hits;
    logic [TIME_W-1:0]    r_vic_age;
    logic [KEY_BITS-1:0]  r_vic_key;
    logic [CNT_W-1:0]     r_used_cnt;

    logic              mine_match, fresh, cand, better, take_free;
    logic [TIME_W-1:0] cage, age;

    always_comb begin
        cage       = i_now - r_cached;
        age        = i_now - r_last;
        mine_match = r_used && (r_key == i_key) && !i_scan.match_ok;
        fresh      = r_live && (cage < i_lifetime);
        cand       = r_used && (r_hits < i_protect);
        better     = cand && (!i_scan.vic_ok || (r_hits < i_vic_hits) ||
                              ((r_hits == i_vic_hits) && (age > i_vic_age)));
        take_free  = !r_used && !i_scan.free_ok;
    end

    // scan wave stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else begin
            r_scan.vld         <= i_scan.vld;
            r_scan.match_ok    <= i_scan.match_ok || mine_match;
            r_scan.match_fresh <= mine_match ? fresh : i_scan.match_fresh;
            r_scan.vic_ok      <= i_scan.vic_ok || better;
            r_scan.free_ok     <= i_scan.free_ok || take_free;
        end
        r_match_idx  <= mine_match ? MY_IDX : i_match_idx;
        r_match_data <= mine_match ? r_data : i_match_data;
        r_vic_idx    <= better ? MY_IDX : i_vic_idx;
        r_vic_hits   <= better ? r_hits : i_vic_hits;
        r_vic_age    <= better ? age : i_vic_age;
        r_vic_key    <= better ? r_key : i_vic_key;
        r_free_idx   <= take_free ? MY_IDX : i_free_idx;
        r_used_cnt   <= i_used_cnt + CNT_W'(r_used);
    end

    // slot state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_live <= 1'b0;
        end else if (i_cmd.clear) begin
            r_used <= 1'b0;
            r_live <= 1'b0;
        end else if (i_cmd.wr_en && (i_cmd_wr_idx == MY_IDX)) begin
            r_used   <= 1'b1;
            r_live   <= 1'b1;
            r_key    <= i_key;
            r_data   <= i_wr_data;
            r_cached <= i_now;
            r_last   <= i_now;
            r_hits   <= '0;
        end else if (i_cmd.hit_en && (i_cmd_match_idx == MY_IDX)) begin
            r_last <= i_now;
            if (r_hits != HIT_MAX) begin
                r_hits <= r_hits + 1'b1;
            end
        end else begin
            if (i_cmd.evict_en && (i_cmd_vic_idx == MY_IDX)) begin
                r_used <= 1'b0;
                r_live <= 1'b0;
            end
            if (i_cmd.kill_en && (i_cmd_match_idx == MY_IDX)) begin
                r_live <= 1'b0;
            end
        end
    end

    assign o_scan       = r_scan;
    assign o_match_idx  = r_match_idx;
    assign o_match_data = r_match_data;
    assign o_vic_idx    = r_vic_idx;
    assign o_vic_hits   = r_vic_hits;
    assign o_vic_age    = r_vic_age;
    assign o_vic_key    = r_vic_key;
    assign o_free_idx   = r_free_idx;
    assign o_used_cnt   = r_used_cnt;

endmodule

// File: rtl/ttl_lfu_cache_policy.sv
// Top level: TTL cache with LFU replacement built on a chain of slot cells.
// Each request: the scan wave visits one cell per cycle down the chain, then the
//   apply state updates the slots and loads the result into the output register,
//   waiting in hold while the output stalls. A new request is taken only in idle.
// Reset (synchronous, active low) empties all slots, zeroes the totals and
//   loads the register defaults; no clearing pass is needed.
module ttl_lfu_cache_policy #(
    parameter int CACHE_SLOTS = 16,
    parameter int KEY_BITS    = 32,
    parameter int DATA_BITS   = 32,
    localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1,
    localparam int CNT_W = $clog2(CACHE_SLOTS + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [ttl_pkg::TIME_W-1:0]    i_now_ticks,
    input  logic                          i_backing_found,
    input  logic [DATA_BITS-1:0]          i_backing_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic                          o_found,
    output logic [DATA_BITS-1:0]          o_data_out,
    output logic                          o_evicted,
    output logic [KEY_BITS-1:0]           o_evicted_key,
    output logic                          o_not_cached,
    output logic [ttl_pkg::TOTAL_W-1:0]   o_hit_total,
    output logic [ttl_pkg::TOTAL_W-1:0]   o_miss_total,
    output logic [ttl_pkg::TOTAL_W-1:0]   o_evict_total,
    output logic [CNT_W-1:0]              o_occupancy,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ttl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ttl_pkg::CFG_W-1:0]     i_cfg_data
);
    import ttl_pkg::*;

    // effective max entries needs room for both the register and the slot count
    localparam int EW = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_HOLD} t_state;

    t_state r_state;

    // configuration registers
    logic [MAXE_W-1:0] r_max_entries;
    logic [TIME_W-1:0] r_lifetime;
    logic [HIT_W-1:0]  r_protect;

    // captured request
    logic                 r_mode, r_bfound, r_inject;
    logic [KEY_BITS-1:0]  r_key;
    logic [TIME_W-1:0]    r_now;
    logic [DATA_BITS-1:0] r_bdata;

    // totals
    logic [TOTAL_W-1:0] r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic [TOTAL_W-1:0] n_hit_cnt, n_miss_cnt, n_evict_cnt;

    // update request latched at the end of the scan
    t_cmd             r_cmd, n_cmd, cmd_live;
    logic [IDX_W-1:0] r_cmd_match_idx, r_cmd_vic_idx, r_cmd_wr_idx;
    logic [IDX_W-1:0] n_wr_idx;

    // pending result, waiting for the output register
    logic                 r_res_hit, r_res_found, r_res_evicted, r_res_notc;
    logic [DATA_BITS-1:0] r_res_data;
    logic [KEY_BITS-1:0]  r_res_ekey;
    logic [CNT_W-1:0]     r_res_occ;
    logic                 n_res_hit, n_res_found, n_res_evicted, n_res_notc;
    logic [DATA_BITS-1:0] n_res_data;
    logic [KEY_BITS-1:0]  n_res_ekey;
    logic [CNT_W-1:0]     n_res_occ;

    // scan chain stages: stage 0 is the injection point, stage CACHE_SLOTS the tail
    t_scan                st_scan      [CACHE_SLOTS+1];
    logic [IDX_W-1:0]     st_match_idx [CACHE_SLOTS+1];
    logic [DATA_BITS-1:0] st_match_data[CACHE_SLOTS+1];
    logic [IDX_W-1:0]     st_vic_idx   [CACHE_SLOTS+1];
    logic [HIT_W-1:0]     st_vic_hits  [CACHE_SLOTS+1];
    logic [TIME_W-1:0]    st_vic_age   [CACHE_SLOTS+1];
    logic [KEY_BITS-1:0]  st_vic_key   [CACHE_SLOTS+1];
    logic [IDX_W-1:0]     st_free_idx  [CACHE_SLOTS+1];
    logic [CNT_W-1:0]     st_used_cnt  [CACHE_SLOTS+1];

    logic out_free, scan_done;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !o_out_valid || !i_out_stall;
    assign scan_done   = st_scan[CACHE_SLOTS].vld;
    // cells only see the update request during the apply cycle
    assign cmd_live    = (r_state == S_APPLY) ? r_cmd : '0;

    always_comb begin
        st_scan[0]       = '0;
        st_scan[0].vld   = r_inject;
        st_match_idx[0]  = '0;
        st_match_data[0] = '0;
        st_vic_idx[0]    = '0;
        st_vic_hits[0]   = '0;
        st_vic_age[0]    = '0;
        st_vic_key[0]    = '0;
        st_free_idx[0]   = '0;
        st_used_cnt[0]   = '0;
    end

    for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
        ttl_cell #(
            .KEY_BITS (KEY_BITS),
            .DATA_BITS(DATA_BITS),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_key          (r_key),
            .i_now          (r_now),
            .i_lifetime     (r_lifetime),
            .i_protect      (r_protect),
            .i_scan         (st_scan[g]),
            .i_match_idx    (st_match_idx[g]),
            .i_match_data   (st_match_data[g]),
            .i_vic_idx      (st_vic_idx[g]),
            .i_vic_hits     (st_vic_hits[g]),
            .i_vic_age      (st_vic_age[g]),
            .i_vic_key      (st_vic_key[g]),
            .i_free_idx     (st_free_idx[g]),
            .i_used_cnt     (st_used_cnt[g]),
            .o_scan         (st_scan[g+1]),
            .o_match_idx    (st_match_idx[g+1]),
            .o_match_data   (st_match_data[g+1]),
            .o_vic_idx      (st_vic_idx[g+1]),
            .o_vic_hits     (st_vic_hits[g+1]),
            .o_vic_age      (st_vic_age[g+1]),
            .o_vic_key      (st_vic_key[g+1]),
            .o_free_idx     (st_free_idx[g+1]),
            .o_used_cnt     (st_used_cnt[g+1]),
            .i_cmd          (cmd_live),
            .i_cmd_match_idx(r_cmd_match_idx),
            .i_cmd_vic_idx  (r_cmd_vic_idx),
            .i_cmd_wr_idx   (r_cmd_wr_idx),
            .i_wr_data      (r_bdata)
        );
    end

    // ---------------------------------------------------------------
    // Decision on the finished scan wave
    // ---------------------------------------------------------------
    t_scan            tl;
    logic [EW-1:0]    eff, used_x, used_after_x;
    logic [CNT_W-1:0] used_after;
    logic             fresh, ins, ev, m_alive, free2_ok, tgt_ok;
    logic [IDX_W-1:0] free2_idx;

    always_comb begin
        tl = st_scan[CACHE_SLOTS];
        // zero acts as one, anything past the slot count as the slot count
        if (r_max_entries == '0) begin
            eff = EW'(1);
        end else if (EW'(r_max_entries) > EW'(CACHE_SLOTS)) begin
            eff = EW'(CACHE_SLOTS);
        end else begin
            eff = EW'(r_max_entries);
        end
        used_x       = EW'(st_used_cnt[CACHE_SLOTS]);
        fresh        = tl.match_ok && tl.match_fresh;
        ins          = !fresh && r_bfound;
        ev           = ins && (used_x >= eff) && tl.vic_ok;
        // the key's own dead slot may itself be the victim
        m_alive      = tl.match_ok &&
                       !(ev && (st_vic_idx[CACHE_SLOTS] == st_match_idx[CACHE_SLOTS]));
        used_after   = st_used_cnt[CACHE_SLOTS] - CNT_W'(ev);
        used_after_x = EW'(used_after);
        // lowest free slot once the victim is gone
        if (ev) begin
            free2_ok  = 1'b1;
            free2_idx = (tl.free_ok &&
                         (st_free_idx[CACHE_SLOTS] < st_vic_idx[CACHE_SLOTS])) ?
                        st_free_idx[CACHE_SLOTS] : st_vic_idx[CACHE_SLOTS];
        end else begin
            free2_ok  = tl.free_ok;
            free2_idx = st_free_idx[CACHE_SLOTS];
        end
        tgt_ok   = ins && (m_alive || ((used_after_x < eff) && free2_ok));
        n_wr_idx = m_alive ? st_match_idx[CACHE_SLOTS] : free2_idx;

        n_cmd          = '0;
        n_cmd.clear    = r_mode;
        n_cmd.hit_en   = !r_mode && fresh;
        n_cmd.kill_en  = !r_mode && !fresh && tl.match_ok;
        n_cmd.evict_en = !r_mode && ev;
        n_cmd.wr_en    = !r_mode && tgt_ok;

        if (r_mode) begin
            n_hit_cnt     = '0;
            n_miss_cnt    = '0;
            n_evict_cnt   = '0;
            n_res_hit     = 1'b0;
            n_res_found   = 1'b0;
            n_res_data    = '0;
            n_res_evicted = 1'b0;
            n_res_ekey    = '0;
            n_res_notc    = 1'b0;
            n_res_occ     = '0;
        end else begin
            n_hit_cnt   = (fresh && (r_hit_cnt != TOTAL_MAX)) ? r_hit_cnt + 1'b1 : r_hit_cnt;
            n_miss_cnt  = (!fresh && (r_miss_cnt != TOTAL_MAX)) ?
                          r_miss_cnt + 1'b1 : r_miss_cnt;
            n_evict_cnt = (ev && (r_evict_cnt != TOTAL_MAX)) ?
                          r_evict_cnt + 1'b1 : r_evict_cnt;
            n_res_hit     = fresh;
            n_res_found   = fresh || r_bfound;
            n_res_data    = fresh ? st_match_data[CACHE_SLOTS] :
                            (r_bfound ? r_bdata : '0);
            n_res_evicted = ev;
            n_res_ekey    = ev ? st_vic_key[CACHE_SLOTS] : '0;
            n_res_notc    = ins && !tgt_ok;
            n_res_occ     = used_after + CNT_W'(tgt_ok && !m_alive);
        end
    end

    // configuration writes; only legal while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= RST_MAX_ENTRIES;
            r_lifetime    <= RST_LIFETIME;
            r_protect     <= RST_PROTECT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[MAXE_W-1:0];
                CFG_LIFETIME:    r_lifetime    <= i_cfg_data[TIME_W-1:0];
                CFG_PROTECT:     r_protect     <= i_cfg_data[HIT_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture and pending result (payload, no reset)
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_mode   <= i_mode;
            r_key    <= i_key;
            r_now    <= i_now_ticks;
            r_bfound <= i_backing_found;
            r_bdata  <= i_backing_data;
        end
        if (scan_done) begin
            r_cmd_match_idx <= st_match_idx[CACHE_SLOTS];
            r_cmd_vic_idx   <= st_vic_idx[CACHE_SLOTS];
            r_cmd_wr_idx    <= n_wr_idx;
            r_res_hit       <= n_res_hit;
            r_res_found     <= n_res_found;
            r_res_data      <= n_res_data;
            r_res_evicted   <= n_res_evicted;
            r_res_ekey      <= n_res_ekey;
            r_res_notc      <= n_res_notc;
            r_res_occ       <= n_res_occ;
        end
    end

    // state, totals and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inject    <= 1'b0;
            r_cmd       <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_inject <= (r_state == S_IDLE) && i_in_valid;
            // taken result drops here; apply and hold reload it below instead
            if (o_out_valid && !i_out_stall &&
                (r_state != S_APPLY) && (r_state != S_HOLD)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_cmd       <= n_cmd;
                        r_hit_cnt   <= n_hit_cnt;
                        r_miss_cnt  <= n_miss_cnt;
                        r_evict_cnt <= n_evict_cnt;
                        r_state     <= S_APPLY;
                    end
                end
                S_APPLY, S_HOLD: begin
                    if (out_free) begin
                        o_out_valid   <= 1'b1;
                        o_hit         <= r_res_hit;
                        o_found       <= r_res_found;
                        o_data_out    <= r_res_data;
                        o_evicted     <= r_res_evicted;
                        o_evicted_key <= r_res_ekey;
                        o_not_cached  <= r_res_notc;
                        o_hit_total   <= r_hit_cnt;
                        o_miss_total  <= r_miss_cnt;
                        o_evict_total <= r_evict_cnt;
                        o_occupancy   <= r_res_occ;
                        r_state       <= S_IDLE;
                    end else begin
                        r_state <= S_HOLD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // the scan wave reaches the tail only while a scan is in flight
    a_scan_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_done |-> (r_state == S_SCAN))
        else $error("scan wave outside scan state");

    // a hit refresh never comes with an insert or a kill for the same request
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> !(r_cmd.hit_en && (r_cmd.wr_en || r_cmd.kill_en)))
        else $error("conflicting slot updates");

    // a hit always returns data and has no insert side effects
    a_hit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> (o_found && !o_evicted && !o_not_cached))
        else $error("hit result with insert side effects");

    // occupancy never exceeds the number of slots
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (EW'(o_occupancy) <= EW'(CACHE_SLOTS)))
        else $error("occupancy out of range");

    // a new result is presented only after an apply or hold cycle
    a_out_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_APPLY || $past(r_state) == S_HOLD))
        else $error("result without a finished request");
`endif

endmodule
